@@ design/ssi_pkg.sv @@
package ssi_pkg;

  // Coordinate width of each result field
  localparam int unsigned COORD_BITS = 13;

  // Default width of the spiral index
  localparam int unsigned DEF_INDEX_BITS = 24;

  typedef logic signed [COORD_BITS-1:0] coord_t;

endpackage

@@ design/square_spiral_index_to_coordinate.sv @@
// A request passes through the root pipeline, the queue and the back-end registers.
// Throughput: one request per cycle while in_ready_o is high; one root digit per stage.
// Reset: asynchronous, active low; clears every valid bit, the credit count and the
// queue pointers. Payload registers are not reset.
module square_spiral_index_to_coordinate import ssi_pkg::*; #(
  parameter int unsigned INDEX_BITS = DEF_INDEX_BITS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [INDEX_BITS-1:0] spiral_index_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output coord_t                coord_x_o,
  output coord_t                coord_y_o
);

  // Root digits, padded index width and queue entry layout
  localparam int unsigned RootBits   = (INDEX_BITS + 1) / 2;
  localparam int unsigned NumBits    = 2 * RootBits;
  localparam int unsigned EntryBits  = NumBits + RootBits;
  // Deep enough to cover every request in the root pipeline plus a little slack,
  // so the front never stalls mid-pipeline
  localparam int unsigned QueueDepth = RootBits + 2;

  logic                 wr_valid;
  logic [NumBits-1:0]   wr_index;
  logic [RootBits-1:0]  wr_ring;
  logic                 q_valid;
  logic [EntryBits-1:0] q_data;
  logic                 back_ready;
  logic                 pop;

  // A request leaves the queue when the back end can take it
  assign pop = q_valid && back_ready;

  // Front: take requests against credit and find the ring with a pipelined root
  ssi_front #(
    .INDEX_BITS  (INDEX_BITS),
    .QUEUE_DEPTH (QueueDepth)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .index_i    (spiral_index_i),
    .pop_i      (pop),
    .wr_valid_o (wr_valid),
    .wr_index_o (wr_index),
    .wr_ring_o  (wr_ring)
  );

  // Hold index and ring between the two halves so each stalls on its own
  ssi_queue #(
    .DATA_BITS (EntryBits),
    .DEPTH     (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (wr_valid),
    .push_data_i ({wr_index, wr_ring}),
    .rd_valid_o  (q_valid),
    .pop_i       (pop),
    .rd_data_o   (q_data)
  );

  // Back: square the ring, locate the edge, drive the output register
  ssi_back #(
    .INDEX_BITS (INDEX_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (q_valid),
    .in_ready_o  (back_ready),
    .index_i     (q_data[EntryBits-1:RootBits]),
    .ring_i      (q_data[RootBits-1:0]),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .coord_x_o   (coord_x_o),
    .coord_y_o   (coord_y_o)
  );

endmodule

@@ design/ssi_front.sv @@
module ssi_front import ssi_pkg::*; #(
  parameter int unsigned INDEX_BITS  = DEF_INDEX_BITS,
  parameter int unsigned QUEUE_DEPTH = (DEF_INDEX_BITS + 1) / 2 + 2
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic [INDEX_BITS-1:0]                 index_i,
  input  logic                                  pop_i,
  output logic                                  wr_valid_o,
  output logic [2*((INDEX_BITS+1)/2)-1:0]       wr_index_o,
  output logic [(INDEX_BITS+1)/2-1:0]           wr_ring_o
);

  localparam int unsigned RootBits = (INDEX_BITS + 1) / 2;
  localparam int unsigned NumBits  = 2 * RootBits;
  localparam int unsigned RemBits  = RootBits + 2;
  localparam int unsigned CntBits  = $clog2(QUEUE_DEPTH + 1);

  logic                  accept;
  logic [CntBits-1:0]    credit_q, credit_d;

  logic [RootBits-1:0]   vld_q;
  logic [NumBits-1:0]    num_q  [RootBits];
  logic [NumBits-1:0]    rad_q  [RootBits];
  logic [RemBits-1:0]    rem_q  [RootBits];
  logic [RootBits-1:0]   root_q [RootBits];

  logic [NumBits-1:0]    num_c  [RootBits];
  logic [NumBits-1:0]    rad_c  [RootBits];
  logic [RemBits-1:0]    rem_c  [RootBits];
  logic [RootBits-1:0]   root_c [RootBits];

  logic [RootBits:0]     root_inc;

  // Count requests in the root pipeline and the queue; stop taking at the queue depth
  assign accept     = in_valid_i && in_ready_o;
  assign in_ready_o = credit_q < CntBits'(QUEUE_DEPTH);

  always_comb begin
    credit_d = credit_q + CntBits'(accept) - CntBits'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      credit_q <= '0;
    end else begin
      credit_q <= credit_d;
    end
  end

  // One root digit per stage, restoring method
  for (genvar i = 0; i < RootBits; i++) begin : g_stage
    logic [NumBits-1:0]  num_in, rad_in;
    logic [RemBits-1:0]  rem_in, rem_t, trial;
    logic [RootBits-1:0] root_in;
    logic                ge;

    if (i == 0) begin : g_first
      assign num_in  = NumBits'(index_i);
      assign rad_in  = NumBits'(index_i);
      assign rem_in  = '0;
      assign root_in = '0;
    end else begin : g_next
      assign num_in  = num_q[i-1];
      assign rad_in  = rad_q[i-1];
      assign rem_in  = rem_q[i-1];
      assign root_in = root_q[i-1];
    end

    always_comb begin
      rem_t     = {rem_in[RemBits-3:0], rad_in[NumBits-1 -: 2]};
      trial     = {root_in, 2'b01};
      ge        = rem_t >= trial;
      rem_c[i]  = ge ? rem_t - trial : rem_t;
      root_c[i] = {root_in[RootBits-2:0], ge};
      rad_c[i]  = rad_in << 2;
      num_c[i]  = num_in;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i] <= 1'b0;
      end else if (i == 0) begin
        vld_q[i] <= accept;
      end else begin
        vld_q[i] <= vld_q[(i == 0) ? 0 : i-1];
      end
    end

    always_ff @(posedge clk_i) begin
      num_q[i]  <= num_c[i];
      rad_q[i]  <= rad_c[i];
      rem_q[i]  <= rem_c[i];
      root_q[i] <= root_c[i];
    end
  end

  // Ring number is the rounded half of the root
  assign root_inc   = {1'b0, root_q[RootBits-1]} + (RootBits+1)'(1);
  assign wr_valid_o = vld_q[RootBits-1];
  assign wr_index_o = num_q[RootBits-1];
  assign wr_ring_o  = root_inc[RootBits:1];

endmodule

@@ design/ssi_queue.sv @@
module ssi_queue import ssi_pkg::*; #(
  parameter int unsigned DATA_BITS = 3 * ((DEF_INDEX_BITS + 1) / 2),
  parameter int unsigned DEPTH     = (DEF_INDEX_BITS + 1) / 2 + 2
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  logic [DATA_BITS-1:0] push_data_i,
  output logic                 rd_valid_o,
  input  logic                 pop_i,
  output logic [DATA_BITS-1:0] rd_data_o
);

  localparam int unsigned PtrBits = $clog2(DEPTH);
  localparam int unsigned CntBits = $clog2(DEPTH + 1);

  logic [DATA_BITS-1:0] mem_q [DEPTH];
  logic [PtrBits-1:0]   wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CntBits-1:0]   cnt_q, cnt_d;
  logic                 pop;

  // Upstream credit keeps pushes within the depth
  assign pop        = pop_i && rd_valid_o;
  assign rd_valid_o = cnt_q != '0;
  assign rd_data_o  = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    if (push_i) begin
      wptr_d = (wptr_q == PtrBits'(DEPTH - 1)) ? '0 : wptr_q + PtrBits'(1);
    end
    if (pop) begin
      rptr_d = (rptr_q == PtrBits'(DEPTH - 1)) ? '0 : rptr_q + PtrBits'(1);
    end
    cnt_d = cnt_q + CntBits'(push_i) - CntBits'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= push_data_i;
    end
  end

endmodule

@@ design/ssi_back.sv @@
module ssi_back import ssi_pkg::*; #(
  parameter int unsigned INDEX_BITS = DEF_INDEX_BITS
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [2*((INDEX_BITS+1)/2)-1:0]   index_i,
  input  logic [(INDEX_BITS+1)/2-1:0]       ring_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output coord_t                            coord_x_o,
  output coord_t                            coord_y_o
);

  localparam int unsigned RootBits = (INDEX_BITS + 1) / 2;
  localparam int unsigned NumBits  = 2 * RootBits;
  localparam int unsigned DiffBits = NumBits + 3;

  logic                       adv1, adv2, adv3;
  logic                       v1_q, v2_q, v3_q;
  logic [NumBits-1:0]         n1_q;
  logic [RootBits-1:0]        k1_q, k2_q;
  logic [NumBits-1:0]         kk1_q;
  logic signed [DiffBits-1:0] d2_q, d2_d;
  logic signed [DiffBits-1:0] tk, d_plus, d_minus;
  logic [COORD_BITS-1:0]      kc, dc, x_d, y_d;
  coord_t                     x_q, y_q;

  assign adv3       = !v3_q || out_ready_i;
  assign adv2       = !v2_q || adv3;
  assign adv1       = !v1_q || adv2;
  assign in_ready_o = adv1;

  // Offset from the bottom-left corner index 4k^2
  always_comb begin
    d2_d = $signed(DiffBits'(n1_q)) - $signed(DiffBits'({kk1_q, 2'b00}));
  end

  // Pick the edge and place the point on it
  always_comb begin
    tk      = $signed(DiffBits'({k2_q, 1'b0}));
    d_plus  = d2_q + tk;
    d_minus = d2_q - tk;
    kc      = COORD_BITS'(k2_q);
    dc      = COORD_BITS'(d2_q);
    if (d_plus <= 0) begin
      x_d = '0 - kc - kc - kc - dc;
      y_d = kc;
    end else if (d2_q <= 0) begin
      x_d = '0 - kc;
      y_d = '0 - kc - dc;
    end else if (d_minus <= 0) begin
      x_d = dc - kc;
      y_d = '0 - kc;
    end else begin
      x_d = kc;
      y_d = dc - kc - kc - kc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (adv1) begin
        v1_q <= in_valid_i;
      end
      if (adv2) begin
        v2_q <= v1_q;
      end
      if (adv3) begin
        v3_q <= v2_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv1) begin
      n1_q  <= index_i;
      k1_q  <= ring_i;
      kk1_q <= NumBits'(ring_i * ring_i);
    end
    if (adv2) begin
      d2_q <= d2_d;
      k2_q <= k1_q;
    end
    if (adv3) begin
      x_q <= coord_t'(x_d);
      y_q <= coord_t'(y_d);
    end
  end

  assign out_valid_o = v3_q;
  assign coord_x_o   = x_q;
  assign coord_y_o   = y_q;

endmodule

@@ tb/spiral_coord_checker.sv @@
`timescale 1ns / 1ps

module spiral_coord_checker import ssi_pkg::*; #(
  parameter int unsigned INDEX_BITS = DEF_INDEX_BITS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_ready_i,
  input  logic [INDEX_BITS-1:0] spiral_index_i,
  input  logic                  out_valid_i,
  input  logic                  out_ready_i,
  input  coord_t                coord_x_i,
  input  coord_t                coord_y_i,
  output int unsigned           mismatch_count_o,
  output int unsigned           awaiting_o
);

  typedef struct packed {
    coord_t x;
    coord_t y;
  } grid_point_t;

  grid_point_t expected_points [$];
  int unsigned mismatches  = 0;
  int unsigned outstanding = 0;

  assign mismatch_count_o = mismatches;
  assign awaiting_o       = outstanding;

  // Floor of the square root, one bit at a time from the top.
  function automatic longint ring_root(longint v);
    longint r;
    longint t;
    r = 0;
    for (int i = 16; i >= 0; i--) begin
      t = r | (longint'(1) << i);
      if (t * t <= v) r = t;
    end
    return r;
  endfunction

  function automatic grid_point_t spiral_point(logic [INDEX_BITS-1:0] idx);
    longint n;
    longint k;
    longint corner;
    longint x;
    longint y;
    grid_point_t p;
    n = idx;
    x = 0;
    y = 0;
    if (n != 0) begin
      k      = (ring_root(n) + 1) / 2;
      corner = 4 * k * k;  // bottom-left corner of ring k
      if (n <= corner - 2 * k) begin
        x = corner - 2 * k - n - k;
        y = k;
      end else if (n <= corner) begin
        x = -k;
        y = corner - n - k;
      end else if (n <= corner + 2 * k) begin
        x = n - corner - k;
        y = -k;
      end else begin
        x = k;
        y = n - corner - 3 * k;
      end
    end
    p.x = x[COORD_BITS-1:0];
    p.y = y[COORD_BITS-1:0];
    return p;
  endfunction

  always @(posedge clk_i) begin
    grid_point_t want;
    if (rst_ni) begin
      if (out_valid_i && out_ready_i) begin
        if (expected_points.size() == 0) begin
          $error("result (%0d, %0d) with no request outstanding", coord_x_i, coord_y_i);
          mismatches++;
        end else begin
          want = expected_points.pop_front();
          if (coord_x_i !== want.x) begin
            $error("coord_x: expected %0d, got %0d", want.x, coord_x_i);
            mismatches++;
          end
          if (coord_y_i !== want.y) begin
            $error("coord_y: expected %0d, got %0d", want.y, coord_y_i);
            mismatches++;
          end
        end
      end
      if (in_valid_i && in_ready_i) expected_points.push_back(spiral_point(spiral_index_i));
      outstanding = expected_points.size();
    end
  end

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
  import ssi_pkg::*;

  localparam int unsigned INDEX_BITS   = DEF_INDEX_BITS;
  localparam int unsigned RANDOM_ITEMS = 900;
  // Drain time is set from the number of root digits.
  localparam int unsigned DRAIN_CYCLES = 4 * ((INDEX_BITS + 1) / 2 + 3);
  localparam int unsigned CYCLE_LIMIT  = 200000;
  // Receiver hold-off window, counted in receiver cycles.
  localparam int unsigned HOLD_FROM    = 150;
  localparam int unsigned HOLD_TO      = 450;
  // Window in which neither side idles.
  localparam int unsigned CALM_FROM    = 1000;
  localparam int unsigned CALM_TO      = 1400;

  logic                  clk            = 1'b0;
  logic                  rst_n          = 1'b0;
  logic                  in_valid       = 1'b0;
  logic                  in_ready;
  logic [INDEX_BITS-1:0] spiral_index   = '0;
  logic                  out_valid;
  logic                  out_ready      = 1'b0;
  coord_t                coord_x;
  coord_t                coord_y;
  int unsigned           mismatches;
  int unsigned           awaiting;
  int unsigned           cycle_count    = 0;
  logic                  calm;

  // Origin, every position of the first ring, corners of the second, squares and
  // their neighbours, the outermost ring's start and top-left corner, the last index and bit patterns.
  logic [INDEX_BITS-1:0] directed_indices [$] = '{
    24'd0, 24'd1, 24'd2, 24'd3, 24'd4, 24'd5, 24'd6, 24'd7, 24'd8,
    24'd9, 24'd12, 24'd16, 24'd20, 24'd24, 24'd25, 24'd48, 24'd49,
    24'd16769024, 24'd16769025, 24'd16773120, 24'd16773121,
    24'hFFFFFF, 24'hAAAAAA, 24'h555555
  };

  always #1 clk = ~clk;

  always @(posedge clk) cycle_count <= cycle_count + 1;

  assign calm = (cycle_count >= CALM_FROM) && (cycle_count < CALM_TO);

  square_spiral_index_to_coordinate #(
    .INDEX_BITS(INDEX_BITS)
  ) u_dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .spiral_index_i(spiral_index),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .coord_x_o     (coord_x),
    .coord_y_o     (coord_y)
  );

  spiral_coord_checker #(
    .INDEX_BITS(INDEX_BITS)
  ) u_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_ready_i      (in_ready),
    .spiral_index_i  (spiral_index),
    .out_valid_i     (out_valid),
    .out_ready_i     (out_ready),
    .coord_x_i       (coord_x),
    .coord_y_i       (coord_y),
    .mismatch_count_o(mismatches),
    .awaiting_o      (awaiting)
  );

  // Draw an index: part uniform over the whole range, part close to a ring corner
  // or a ring start, part among the small inner rings.
  function automatic logic [INDEX_BITS-1:0] draw_index();
    longint      ring;
    longint      v;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 40) begin
      v = $urandom_range(24'hFFFFFF);
    end else if (pick < 70) begin
      ring = $urandom_range(2047, 1);
      // Ring start, top-left, bottom-left, bottom-right or top-right corner.
      v = 4 * ring * ring + 2 * ring * (longint'($urandom_range(3)) - 1);
      if ($urandom_range(4) == 0) v = (2 * ring - 1) * (2 * ring - 1);
      v = v + longint'($urandom_range(4)) - 2;
    end else begin
      v = $urandom_range(1000);
    end
    if (v < 0) v = 0;
    if (v > 24'hFFFFFF) v = 24'hFFFFFF;
    return v[INDEX_BITS-1:0];
  endfunction

  // Offer one request: idle at random first (not in the calm window), then raise
  // valid with the index and hold both until the block accepts it.
  task automatic push_index(input logic [INDEX_BITS-1:0] idx);
    while (!calm && $urandom_range(99) < 37) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    spiral_index <= idx;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // Receiver: drop ready for a long stretch early on so the block fills up and
  // stalls its input, otherwise stall at random except in the calm window.
  initial begin : result_drain
    int unsigned rx_cycle;
    rx_cycle = 0;
    forever begin
      @(negedge clk);
      rx_cycle++;
      if (rx_cycle >= HOLD_FROM && rx_cycle < HOLD_TO) begin
        out_ready <= 1'b0;
      end else if (calm) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(99) >= 37);
      end
    end
  end

  // Abandon the run if it hangs.
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin : request_source
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    foreach (directed_indices[i]) push_index(directed_indices[i]);
    repeat (RANDOM_ITEMS) push_index(draw_index());
    in_valid <= 1'b0;
    // Wait for every outstanding result, then a little longer to catch strays.
    while (awaiting != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && awaiting == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
